>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TZA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tza assertion failed");

// Clocked assertion that is also checked across reset.
`define TZA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tza reset assertion failed");

`endif

>>> design/tza_pkg.sv
// Package with the types, constants and defaults of the zoned trapezoid area sum.
`timescale 1ns / 1ps
package tza_pkg;

  // Parameter defaults.
  localparam int FRAME_LEN_DEF   = 128;
  localparam int LEFT_LEN_DEF    = 43;
  localparam int MID_LEN_DEF     = 42;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths.
  localparam int IN_SAMPLE_W = 13;
  localparam int MAG_W       = 12;
  localparam int SUM_W       = 20;
  localparam int AREA_W      = 16;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Division by ten as a multiply by ceil(2^23 / 10) and a shift; exact below 2^22.
  localparam int                     DIV10_RECIP_W = 20;
  localparam logic [DIV10_RECIP_W-1:0] DIV10_RECIP = 20'hCCCCD;
  localparam int                     DIV10_SHIFT   = 23;

  // One input item.
  typedef struct packed {
    logic signed [IN_SAMPLE_W-1:0] sample;
    logic                          frame_end;
  } tza_in_t;

  // One result item.
  typedef struct packed {
    logic [AREA_W-1:0] left_area;
    logic [AREA_W-1:0] middle_area;
    logic [AREA_W-1:0] right_area;
  } tza_out_t;

  // The three zone accumulators.
  typedef struct packed {
    logic [SUM_W-1:0] left_sum;
    logic [SUM_W-1:0] middle_sum;
    logic [SUM_W-1:0] right_sum;
  } tza_sums_t;

endpackage

>>> design/tza_accum.sv
// Zone tracking, trapezoid area step and saturating zone accumulators.
`timescale 1ns / 1ps
module tza_accum import tza_pkg::*; #(
  parameter int FRAME_LEN   = FRAME_LEN_DEF,
  parameter int LEFT_LEN    = LEFT_LEN_DEF,
  parameter int MID_LEN     = MID_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  tza_in_t   item,
  output tza_sums_t sums_nxt
);

  localparam int POS_W  = $clog2(FRAME_LEN + 1);
  localparam int IDX_W  = $clog2(FRAME_LEN);
  localparam int CMP_W  = POS_W + 9;
  localparam int VCMP_W = (SAMPLE_BITS > MAG_W) ? SAMPLE_BITS : MAG_W;
  localparam int PROD_W = SAMPLE_BITS + POS_W;
  localparam int ADD_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

  localparam logic [VCMP_W-1:0]      V_MAX_CMP = VCMP_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [SAMPLE_BITS-1:0] V_MAX     = {SAMPLE_BITS{1'b1}};

  logic [POS_W-1:0]       position_r;
  tza_sums_t              sums_r;
  logic [SAMPLE_BITS-1:0] anchor_value_r;
  logic [IDX_W-1:0]       anchor_index_r;
  logic                   anchor_valid_r;

  logic [CMP_W-1:0]       pos_ext;
  logic                   in_left;
  logic                   in_mid;
  logic [CMP_W-1:0]       zone_start;
  logic [IDX_W-1:0]       idx;
  logic                   active;
  logic                   zone_first;
  logic                   skip;
  logic [SAMPLE_BITS-1:0] v;
  logic [SAMPLE_BITS:0]   pair_sum;
  logic [SAMPLE_BITS-1:0] half;
  logic [POS_W-1:0]       height;
  logic [PROD_W-1:0]      area;
  logic                   add_en;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [PROD_W-1:0] inc);
    logic [ADD_W-1:0] s;
    s = ADD_W'(acc) + ADD_W'(inc);
    sat_add = (s > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
  endfunction

  // Zone of the current position and the index within that zone.
  always_comb begin
    pos_ext = CMP_W'(position_r);
    active  = position_r < POS_W'(FRAME_LEN);
    in_left = pos_ext < CMP_W'(LEFT_LEN);
    in_mid  = !in_left && (pos_ext < CMP_W'(LEFT_LEN + MID_LEN));
    if (in_left) begin
      zone_start = '0;
    end else if (in_mid) begin
      zone_start = CMP_W'(LEFT_LEN);
    end else begin
      zone_start = CMP_W'(LEFT_LEN + MID_LEN);
    end
    idx        = IDX_W'(pos_ext - zone_start);
    zone_first = (idx == '0);
  end

  // Sample decode: all ones is a missing point, other negatives count as zero, larger values clamp to the maximum.
  always_comb begin
    skip = (item.sample == '1);
    if (item.sample[IN_SAMPLE_W-1]) begin
      v = '0;
    end else if (VCMP_W'(item.sample[MAG_W-1:0]) > V_MAX_CMP) begin
      v = V_MAX;
    end else begin
      v = SAMPLE_BITS'(item.sample[MAG_W-1:0]);
    end
  end

  // Trapezoid step against the anchor; the height keeps the extra one.
  always_comb begin
    pair_sum = {1'b0, v} + {1'b0, anchor_value_r};
    half     = pair_sum[SAMPLE_BITS:1];
    height   = POS_W'(idx) + POS_W'(1) - POS_W'(anchor_index_r);
    area     = PROD_W'(half) * PROD_W'(height);
    add_en   = active && !skip && anchor_valid_r && !zone_first;
  end

  // Accumulator values after this item.
  always_comb begin
    sums_nxt = sums_r;
    if (add_en) begin
      if (in_left) begin
        sums_nxt.left_sum = sat_add(sums_r.left_sum, area);
      end else if (in_mid) begin
        sums_nxt.middle_sum = sat_add(sums_r.middle_sum, area);
      end else begin
        sums_nxt.right_sum = sat_add(sums_r.right_sum, area);
      end
    end
  end

  // State update; the end of a frame clears everything for the next one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r     <= '0;
      sums_r         <= '0;
      anchor_valid_r <= 1'b0;
    end else if (step) begin
      if (item.frame_end) begin
        position_r     <= '0;
        sums_r         <= '0;
        anchor_valid_r <= 1'b0;
      end else if (active) begin
        position_r <= position_r + POS_W'(1);
        sums_r     <= sums_nxt;
        if (!skip) begin
          anchor_valid_r <= 1'b1;
        end else if (zone_first) begin
          anchor_valid_r <= 1'b0;
        end
      end
    end
  end

  // Anchor payload needs no reset.
  always_ff @(posedge clk) begin
    if (step && active && !skip) begin
      anchor_value_r <= v;
      anchor_index_r <= idx;
    end
  end

endmodule

>>> design/tza_div10.sv
// Divide a zone sum by ten and saturate it to the area width.
`timescale 1ns / 1ps
module tza_div10 import tza_pkg::*; (
  input  logic [SUM_W-1:0]  sum,
  output logic [AREA_W-1:0] area
);

  localparam int PROD_W = SUM_W + DIV10_RECIP_W;
  localparam int Q_W    = PROD_W - DIV10_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    quot;

  // Reciprocal multiply, then clamp the quotient.
  always_comb begin
    prod = PROD_W'(sum) * PROD_W'(DIV10_RECIP);
    quot = prod[PROD_W-1:DIV10_SHIFT];
    area = (quot > Q_W'(AREA_MAX)) ? AREA_MAX : AREA_W'(quot);
  end

endmodule

>>> design/zoned_trapezoid_area_sum_top.sv
// Zoned trapezoid area sum: one sample per cycle in while in_ready is high, three
// zone areas out per frame. The block accepts one sample in every clock cycle in
// which in_ready is high. Each sample goes through an input register, then the
// area step and accumulate; a sample flagged frame_end also loads the final sums
// into a register, from which they are divided by ten into the output register
// once that register is free. The output register holds a waiting result while
// further samples of the next frame keep flowing; input ready drops only when a
// frame_end sample would overrun a result still waiting to be taken.
`timescale 1ns / 1ps
module zoned_trapezoid_area_sum_top import tza_pkg::*; #(
  parameter int FRAME_LEN   = FRAME_LEN_DEF,
  parameter int LEFT_LEN    = LEFT_LEN_DEF,
  parameter int MID_LEN     = MID_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tza_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tza_out_t out_data
);

  tza_in_t   in_r;
  logic      in_valid_r;
  tza_sums_t fin_sums_r;
  logic      fin_valid_r;
  tza_out_t  out_r;
  logic      out_valid_r;

  tza_sums_t sums_nxt;
  tza_out_t  scaled;
  logic      out_free;
  logic      fin_move;
  logic      fin_free;
  logic      in_move;

  // Stage handshake: each stage moves when the next one is free or draining.
  always_comb begin
    out_free = !out_valid_r || out_ready;
    fin_move = fin_valid_r && out_free;
    fin_free = !fin_valid_r || out_free;
    in_move  = in_valid_r && (!in_r.frame_end || fin_free);
    in_ready = !in_valid_r || in_move;
  end

  tza_accum #(
    .FRAME_LEN  (FRAME_LEN),
    .LEFT_LEN   (LEFT_LEN),
    .MID_LEN    (MID_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_move),
    .item    (in_r),
    .sums_nxt(sums_nxt)
  );

  tza_div10 u_div_left  (.sum(fin_sums_r.left_sum),   .area(scaled.left_area));
  tza_div10 u_div_mid   (.sum(fin_sums_r.middle_sum), .area(scaled.middle_area));
  tza_div10 u_div_right (.sum(fin_sums_r.right_sum),  .area(scaled.right_area));

  // Valid flags of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (fin_free) begin
        fin_valid_r <= in_move && in_r.frame_end;
      end
      if (out_free) begin
        out_valid_r <= fin_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (in_move && in_r.frame_end) begin
      fin_sums_r <= sums_nxt;
    end
    if (fin_move) begin
      out_r <= scaled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/tza_checker.sv
// Port-level checker for the zoned trapezoid area sum and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tza_checker import tza_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input tza_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input tza_out_t out_data
);

  // A stalled result holds its value.
  `TZA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // No result is offered right after reset.
  `TZA_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid)

  // The input never stalls while the output side can take a result.
  `TZA_ASSERT(a_no_stall, (!out_valid || out_ready) |-> in_ready)

  // A frame end with a draining output yields a result through the final-sum and output registers.
  `TZA_ASSERT(a_frame_result,
    (in_valid && in_ready && in_data.frame_end) ##1 out_ready ##1 out_ready |=> out_valid)

endmodule

bind zoned_trapezoid_area_sum_top tza_checker u_tza_checker (.*);
